// ===== rtl/mersenne_twister_prng_defines.svh =====
// Assertion macros shared by the generator RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef MERSENNE_TWISTER_PRNG_DEFINES_SVH
`define MERSENNE_TWISTER_PRNG_DEFINES_SVH

// Checked property, disabled while reset is asserted.
`define MTP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("generator assertion failed");

// Checked property, also evaluated during reset.
`define MTP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("generator assertion failed during or after reset");

`endif

// ===== rtl/mtp_pkg.sv =====
// Types and constants of the MT19937 generator.
// Depends on nothing; used by the result channel interface and the top level.
`timescale 1ns / 1ps

package mtp_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned StateSize   = 624;
  localparam int unsigned TwistOffset = 397;
  localparam int unsigned IdxW        = 10;

  typedef logic [IdxW-1:0] idx_t;

  localparam idx_t  NotInit    = idx_t'(625);
  localparam word_t SeedReset  = 32'd12345678;
  localparam word_t MatA       = 32'h9908_b0df;
  localparam word_t InitMult   = 32'd1812433253;
  localparam word_t UpperMask  = 32'h8000_0000;
  localparam word_t LowerMask  = 32'h7fff_ffff;
  localparam word_t TemperB    = 32'h9d2c_5680;
  localparam word_t TemperC    = 32'hefc6_0000;

endpackage

// ===== rtl/mtp_req_if.sv =====
// Request channel of the generator: valid, ready and the restart flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface mtp_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// ===== rtl/mtp_rsp_if.sv =====
// Result channel of the generator: valid, ready and one tempered word.
// Depends on mtp_pkg for the word type.
`timescale 1ns / 1ps

interface mtp_rsp_if;
  logic           valid;
  logic           ready;
  mtp_pkg::word_t random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

// ===== rtl/mersenne_twister_prng.sv =====
// Top level of the MT19937 generator: state memory, seed register and sequencer.
// Depends on mtp_pkg, mtp_req_if, mtp_rsp_if and mersenne_twister_prng_defines.svh.
//
//   Channel   Direction  Payload              Moves
//   req_i     in         restart (1 bit)      one request per word
//   rsp_o     out        random_word (32 b)   one tempered word per request
//   seed_*_i  in         seed (32 bits)       register write, no read-back
//
// A request passes through accept, memory read, and twist with write-back.
// A fill from the seed adds a multiply step and an add step per word, sharing the single multiplier.
// Reset is asynchronous and leaves the memory as it is; the first request fills it.
// One request is accepted while a word waits in the result register.
// That request then stalls in the twist step until the result is taken.
`timescale 1ns / 1ps

`include "mersenne_twister_prng_defines.svh"

module mersenne_twister_prng (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           seed_we_i,
  input  mtp_pkg::word_t seed_wdata_i,
  mtp_req_if.sink        req_i,
  mtp_rsp_if.source      rsp_o
);

  typedef enum logic [2:0] {
    StIdle,
    StFillMul,
    StFillAdd,
    StRead,
    StTwist
  } state_e;

  localparam mtp_pkg::idx_t LastIdx  = mtp_pkg::idx_t'(mtp_pkg::StateSize - 1);
  localparam mtp_pkg::idx_t FarSplit =
      mtp_pkg::idx_t'(mtp_pkg::StateSize - mtp_pkg::TwistOffset);
  localparam mtp_pkg::idx_t FarOfs   = mtp_pkg::idx_t'(mtp_pkg::TwistOffset);

  state_e         state_q;
  mtp_pkg::word_t seed_q;
  mtp_pkg::idx_t  idx_q;
  mtp_pkg::idx_t  fill_k_q;
  mtp_pkg::word_t prev_q;
  mtp_pkg::word_t prod_q;
  mtp_pkg::word_t cur_q;
  logic           out_valid_q;
  mtp_pkg::word_t out_word_q;

  mtp_pkg::word_t mem [mtp_pkg::StateSize];
  mtp_pkg::word_t rd_nxt_q;
  mtp_pkg::word_t rd_far_q;

  logic           req_fire;
  logic           need_fill;
  logic           can_emit;
  logic           mem_we;
  mtp_pkg::idx_t  mem_waddr;
  mtp_pkg::word_t mem_wdata;
  logic           rd_en;
  mtp_pkg::idx_t  nxt_idx;
  mtp_pkg::idx_t  far_idx;
  mtp_pkg::word_t fill_val;
  mtp_pkg::word_t mix;
  mtp_pkg::word_t twist_h;
  mtp_pkg::word_t twist_v;

  function automatic mtp_pkg::word_t temper(input mtp_pkg::word_t e);
    mtp_pkg::word_t t;
    t = e ^ (e >> 11);
    t = t ^ ((t << 7) & mtp_pkg::TemperB);
    t = t ^ ((t << 15) & mtp_pkg::TemperC);
    t = t ^ (t >> 18);
    return t;
  endfunction

  assign req_i.ready     = (state_q == StIdle);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.random_word = out_word_q;

  assign req_fire  = req_i.valid && req_i.ready;
  assign need_fill = req_i.restart || (idx_q >= mtp_pkg::idx_t'(mtp_pkg::StateSize));
  assign can_emit  = !out_valid_q || rsp_o.ready;

  assign nxt_idx  = (idx_q == LastIdx) ? '0 : idx_q + mtp_pkg::idx_t'(1);
  assign far_idx  = (idx_q < FarSplit) ? idx_q + FarOfs : idx_q - FarSplit;
  assign fill_val = prod_q + {{(32 - mtp_pkg::IdxW){1'b0}}, fill_k_q};
  assign mix      = prev_q ^ (prev_q >> 30);
  assign twist_h  = (cur_q & mtp_pkg::UpperMask) | (rd_nxt_q & mtp_pkg::LowerMask);
  assign twist_v  = rd_far_q ^ (twist_h >> 1) ^ (twist_h[0] ? mtp_pkg::MatA : '0);
  assign rd_en    = (state_q == StRead);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = twist_v;
    unique case (state_q)
      StIdle: begin
        if (req_fire && need_fill) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = seed_q;
        end
      end
      StFillAdd: begin
        mem_we    = 1'b1;
        mem_waddr = fill_k_q;
        mem_wdata = fill_val;
      end
      StTwist: begin
        mem_we = can_emit;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_nxt_q <= mem[nxt_idx];
      rd_far_q <= mem[far_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= mtp_pkg::SeedReset;
    end else if (seed_we_i) begin
      seed_q <= seed_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= mtp_pkg::NotInit;
      fill_k_q    <= '0;
      prev_q      <= '0;
      prod_q      <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (req_fire) begin
            if (need_fill) begin
              prev_q   <= seed_q;
              cur_q    <= seed_q;
              fill_k_q <= mtp_pkg::idx_t'(1);
              state_q  <= StFillMul;
            end else begin
              state_q <= StRead;
            end
          end
        end
        StFillMul: begin
          prod_q  <= mtp_pkg::InitMult * mix;
          state_q <= StFillAdd;
        end
        StFillAdd: begin
          prev_q <= fill_val;
          if (fill_k_q == LastIdx) begin
            idx_q   <= '0;
            state_q <= StRead;
          end else begin
            fill_k_q <= fill_k_q + mtp_pkg::idx_t'(1);
            state_q  <= StFillMul;
          end
        end
        StRead: begin
          state_q <= StTwist;
        end
        StTwist: begin
          if (can_emit) begin
            out_valid_q <= 1'b1;
            out_word_q  <= temper(twist_v);
            cur_q       <= rd_nxt_q;
            idx_q       <= nxt_idx;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Memory reads and writes never share a cycle, so no bypass is needed.
  `MTP_ASSERT_ALWAYS(a_no_rw_overlap, clk_i, !(mem_we && rd_en))
  `MTP_ASSERT(a_idx_legal, clk_i, rst_ni,
      (idx_q < mtp_pkg::idx_t'(mtp_pkg::StateSize)) || (idx_q == mtp_pkg::NotInit))
  `MTP_ASSERT(a_fill_k_range, clk_i, rst_ni,
      ((state_q == StFillMul) || (state_q == StFillAdd)) |->
      ((fill_k_q != '0) && (fill_k_q <= LastIdx)))
  `MTP_ASSERT(a_result_from_twist, clk_i, rst_ni,
      $rose(out_valid_q) |-> ($past(state_q) == StTwist))

endmodule
